// ----- rtl/core/id3tfp_pkg.sv -----
package id3tfp_pkg;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_TAG_FOUND = 3'd0,
        KIND_NO_TAG    = 3'd1,
        KIND_TEXT      = 3'd2,
        KIND_FIELD_END = 3'd3,
        KIND_WALK_END  = 3'd4
    } kind_t;

    // Text field codes
    typedef enum logic [2:0] {
        FIELD_TITLE   = 3'd0,
        FIELD_ARTIST  = 3'd1,
        FIELD_ALBUM   = 3'd2,
        FIELD_YEAR    = 3'd3,
        FIELD_GENRE   = 3'd4,
        FIELD_COMMENT = 3'd5,
        FIELD_NONE    = 3'd7
    } field_t;

    localparam logic [7:0]  MAGIC_0    = 8'h49; // 'I'
    localparam logic [7:0]  MAGIC_1    = 8'h44; // 'D'
    localparam logic [7:0]  MAGIC_2    = 8'h33; // '3'
    localparam logic [7:0]  SYNC_MASK  = 8'h7F;
    localparam logic [31:0] ID_TIT2    = 32'h54495432;
    localparam logic [31:0] ID_TPE1    = 32'h54504531;
    localparam logic [31:0] ID_TALB    = 32'h54414C42;
    localparam logic [31:0] ID_TYER    = 32'h54594552;
    localparam logic [31:0] ID_TCON    = 32'h54434F4E;
    localparam logic [31:0] ID_COMM    = 32'h434F4D4D;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [27:0] tag_len;
        logic [2:0]  field_code;
        logic [7:0]  text_byte;
        logic        ends_field;
    } out_item_t;

    // Classified event passed from front to back
    typedef struct packed {
        kind_t       kind;
        field_t      field;
        logic [7:0]  data;
        logic        last;
        logic [27:0] size;
    } event_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [7:0] magic_char(input logic [1:0] pos);
        logic [7:0] c;
        unique case (pos)
            2'd0:    c = MAGIC_0;
            2'd1:    c = MAGIC_1;
            default: c = MAGIC_2;
        endcase
        return c;
    endfunction

    function automatic field_t lookup_field(input logic [31:0] id);
        field_t f;
        priority if (id == ID_TIT2) f = FIELD_TITLE;
        else if (id == ID_TPE1)     f = FIELD_ARTIST;
        else if (id == ID_TALB)     f = FIELD_ALBUM;
        else if (id == ID_TYER)     f = FIELD_YEAR;
        else if (id == ID_TCON)     f = FIELD_GENRE;
        else if (id == ID_COMM)     f = FIELD_COMMENT;
        else                        f = FIELD_NONE;
        return f;
    endfunction

endpackage

// ----- rtl/core/id3tfp_front.sv -----
module id3tfp_front
    import id3tfp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  in_item_t item,
    output logic     push,
    output event_t   ev
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_FRAMEHDR,
        PH_PAYLOAD,
        PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  pos_reg, pos_next;
    logic        magic_reg, magic_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] ident_reg, ident_next;
    field_t      field_reg, field_next;
    logic        open_reg, open_next;

    always_comb
    begin
        phase_t      ph;
        logic [3:0]  pos;
        logic        mg;
        logic [31:0] acc;
        logic [31:0] ident;
        field_t      fld;
        logic        opn;
        logic [31:0] rem;
        logic        last;
        logic [7:0]  d;

        d     = item.data_byte;
        ph    = phase_reg;
        pos   = pos_reg;
        mg    = magic_reg;
        acc   = acc_reg;
        ident = ident_reg;
        fld   = field_reg;
        opn   = open_reg;
        rem   = '0;
        last  = 1'b0;

        push     = 1'b0;
        ev.kind  = KIND_WALK_END;
        ev.field = field_reg;
        ev.data  = d;
        ev.last  = 1'b0;
        ev.size  = '0;

        // restart on a new file
        if (item.first_byte)
        begin
            ph    = PH_HEADER;
            pos   = '0;
            mg    = 1'b1;
            acc   = '0;
            ident = '0;
            fld   = FIELD_NONE;
            opn   = 1'b0;
        end

        unique case (ph)
            PH_HEADER:
            begin
                if (pos < 4'd3 && d != magic_char(pos[1:0]))
                begin
                    mg = 1'b0;
                end
                if (pos >= 4'd6)
                begin
                    acc = {acc[24:0], d[6:0] & SYNC_MASK[6:0]};
                end
                if (pos >= 4'd9)
                begin
                    push = 1'b1;
                    if (mg)
                    begin
                        ev.kind = KIND_TAG_FOUND;
                        ev.size = acc[27:0];
                        ph      = PH_FRAMEHDR;
                        pos     = '0;
                        acc     = '0;
                        ident   = '0;
                        fld     = FIELD_NONE;
                        opn     = 1'b0;
                    end
                    else
                    begin
                        ev.kind = KIND_NO_TAG;
                        ph      = PH_DONE;
                    end
                end
                else
                begin
                    pos = pos + 4'd1;
                end
            end

            PH_FRAMEHDR:
            begin
                if (pos == 4'd0 && d == 8'd0)
                begin
                    push    = 1'b1;
                    ev.kind = KIND_WALK_END;
                    ph      = PH_DONE;
                end
                else
                begin
                    if (pos < 4'd4)
                    begin
                        ident = {ident[23:0], d};
                    end
                    else if (pos < 4'd8)
                    begin
                        acc = {acc[23:0], d};
                    end
                    if (pos >= 4'd9)
                    begin
                        if (acc == 32'd0)
                        begin
                            push    = 1'b1;
                            ev.kind = KIND_WALK_END;
                            ph      = PH_DONE;
                        end
                        else
                        begin
                            fld = lookup_field(ident);
                            opn = 1'b0;
                            pos = '0;
                            ph  = PH_PAYLOAD;
                        end
                    end
                    else
                    begin
                        pos = pos + 4'd1;
                    end
                end
            end

            PH_PAYLOAD:
            begin
                rem     = acc - 32'd1;
                last    = (rem == 32'd0);
                acc     = rem;
                ev.last = last;
                if (pos == 4'd0)
                begin
                    // skip the encoding byte
                    pos = 4'd1;
                    if (fld != FIELD_NONE)
                    begin
                        if (last)
                        begin
                            push    = 1'b1;
                            ev.kind = KIND_FIELD_END;
                        end
                        else
                        begin
                            opn = 1'b1;
                        end
                    end
                end
                else if (opn)
                begin
                    push = 1'b1;
                    if (d == 8'd0)
                    begin
                        ev.kind = KIND_FIELD_END;
                        opn     = 1'b0;
                    end
                    else
                    begin
                        ev.kind = KIND_TEXT;
                    end
                end
                ev.field = fld;
                if (last)
                begin
                    ph    = PH_FRAMEHDR;
                    pos   = '0;
                    acc   = '0;
                    ident = '0;
                    fld   = FIELD_NONE;
                    opn   = 1'b0;
                end
            end

            PH_DONE:
            begin
                // drop bytes until the next file
            end
        endcase

        if (!accept)
        begin
            push = 1'b0;
        end

        phase_next = ph;
        pos_next   = pos;
        magic_next = mg;
        acc_next   = acc;
        ident_next = ident;
        field_next = fld;
        open_next  = opn;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            pos_reg   <= '0;
            magic_reg <= 1'b1;
            acc_reg   <= '0;
            ident_reg <= '0;
            field_reg <= FIELD_NONE;
            open_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            magic_reg <= magic_next;
            acc_reg   <= acc_next;
            ident_reg <= ident_next;
            field_reg <= field_next;
            open_reg  <= open_next;
        end
    end

endmodule

// ----- rtl/core/id3tfp_queue.sv -----
module id3tfp_queue
    import id3tfp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  event_t        push_ev,
    input  logic          pop,
    output event_t        head,
    output queue_status_t status
);

    localparam int PtrW = $clog2(QUEUE_DEPTH);

    event_t              mem_reg [QUEUE_DEPTH];
    logic [PtrW-1:0]     wr_ptr_reg;
    logic [PtrW-1:0]     rd_ptr_reg;
    logic [PtrW:0]       count_reg;
    logic                do_push;
    logic                do_pop;

    assign status.full  = (count_reg == (PtrW+1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_ev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ----- rtl/core/id3tfp_back.sv -----
module id3tfp_back
    import id3tfp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  event_t        head,
    input  queue_status_t status,
    output logic          pop,
    output logic          valid,
    input  logic          stall,
    output out_item_t     item
);

    logic      valid_reg;
    out_item_t item_reg, item_next;

    // load when the output slot is free or being taken
    assign pop   = !status.empty && (!valid_reg || !stall);
    assign valid = valid_reg;
    assign item  = item_reg;

    always_comb
    begin
        logic is_text;
        logic has_field;

        is_text   = (head.kind == KIND_TEXT);
        has_field = is_text || (head.kind == KIND_FIELD_END);

        item_next.kind       = head.kind;
        item_next.tag_len    = (head.kind == KIND_TAG_FOUND) ? head.size : '0;
        item_next.field_code = has_field ? head.field : 3'd0;
        item_next.text_byte  = is_text ? head.data : 8'd0;
        item_next.ends_field = is_text ? head.last : 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= item_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (!stall)
        begin
            valid_reg <= 1'b0;
        end
    end

endmodule

// ----- rtl/core/id3v2_text_frame_parser_core.sv -----
// Channel   Dir  Payload      Handshake                 Meaning
// byte      in   in_item_t    byte_valid/byte_stall     one file byte, restart mark
// result    out  out_item_t   result_valid/result_stall tag, text and walk events
//
// One byte is taken every cycle while byte_stall is low; the frame walk is a
// single compare and count per byte in the front classifier. A result is
// registered in the queue, then in the output register, before its handshake.
// Reset (rst_n low, asynchronous) clears the parser to the tag header phase and
// empties the two-entry event queue and the output register.
// byte_stall rises only when the queue is full. With a result on every byte a
// stalled result fills it, so byte_stall then follows result_stall from the next
// cycle; with fewer results the front keeps parsing while one waits.
module id3v2_text_frame_parser_core
    import id3tfp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_stall,
    input  in_item_t  byte_item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result_item
);

    queue_status_t q_status;
    event_t        front_ev;
    event_t        q_head;
    logic          front_push;
    logic          back_pop;
    logic          accept;

    // hold the byte side while the queue has no room
    assign byte_stall = q_status.full;
    assign accept     = byte_valid && !byte_stall;

    // front: parse each accepted byte, push an event when it makes a result
    id3tfp_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (byte_item),
        .push   (front_push),
        .ev     (front_ev)
    );

    // decouple parsing from the output handshake
    id3tfp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (front_push),
        .push_ev (front_ev),
        .pop     (back_pop),
        .head    (q_head),
        .status  (q_status)
    );

    // back: format the event into the registered result item
    id3tfp_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (q_head),
        .status (q_status),
        .pop    (back_pop),
        .valid  (result_valid),
        .stall  (result_stall),
        .item   (result_item)
    );

endmodule

// ----- tb/id3v2_text_frame_parser_core_tb.sv -----
`timescale 1ns / 1ps

module id3v2_text_frame_parser_core_tb;

    import id3tfp_pkg::*;

    // Stop feeding files once this many bytes have landed in a live parser phase
    localparam int ITEM_TARGET = 1600;

    // Frame IDs that carry text, in field-code order
    localparam logic [31:0] TEXT_IDS [6] = '{ID_TIT2, ID_TPE1, ID_TALB,
                                              ID_TYER, ID_TCON, ID_COMM};
    localparam logic [7:0]  MAGIC_BYTES [3] = '{MAGIC_0, MAGIC_1, MAGIC_2};

    // Opening file, sent without a restart mark: tag header with every size
    // byte at 0xFF (the mask must drop bit 7), one TIT2 frame whose single
    // text byte is 0xFF and closes the field, then a zero byte ending the walk.
    localparam logic [7:0] OPENING [23] = '{
        MAGIC_0, MAGIC_1, MAGIC_2, 8'h03, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        "T", "I", "T", "2", 8'h00, 8'h00, 8'h00, 8'h02, 8'hFF, 8'hFF,
        8'h00, 8'hFF,
        8'h00
    };

    typedef enum logic [1:0] {
        P_TAG_HDR,
        P_FRAME_HDR,
        P_PAYLOAD,
        P_IDLE
    } walk_phase_t;

    // Tracks the parser state on its own, predicts the result each accepted
    // byte causes, and matches results against the oldest prediction.
    class text_frame_scoreboard;
        out_item_t   expected_q[$];
        int          failures;
        int          live_bytes;
        walk_phase_t phase;
        logic [3:0]  pos;
        logic        magic_ok;
        logic [31:0] acc;
        logic [31:0] ident;
        logic [31:0] remaining;
        field_t      field;
        logic        text_open;

        function new();
            restart();
            failures   = 0;
            live_bytes = 0;
        endfunction

        function void restart();
            phase     = P_TAG_HDR;
            pos       = '0;
            magic_ok  = 1'b1;
            acc       = '0;
            ident     = '0;
            remaining = '0;
            field     = FIELD_NONE;
            text_open = 1'b0;
        endfunction

        function void open_frame_header();
            phase     = P_FRAME_HDR;
            pos       = '0;
            acc       = '0;
            ident     = '0;
            remaining = '0;
            field     = FIELD_NONE;
            text_open = 1'b0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_byte(in_item_t it);
            out_item_t  r;
            logic       emit;
            logic       last;
            logic [7:0] d;
            int         i;
            d    = it.data_byte;
            r    = '0;
            emit = 1'b0;
            if (it.first_byte)
                restart();
            if (phase != P_IDLE)
                live_bytes++;
            case (phase)
                P_TAG_HDR:
                begin
                    if (pos < 3 && d != MAGIC_BYTES[pos])
                        magic_ok = 1'b0;
                    if (pos >= 6)
                        acc = (acc << 7) | 32'(d & SYNC_MASK);
                    if (pos >= 9)
                    begin
                        emit = 1'b1;
                        if (magic_ok)
                        begin
                            r.kind    = KIND_TAG_FOUND;
                            r.tag_len = acc[27:0];
                            open_frame_header();
                        end
                        else
                        begin
                            r.kind = KIND_NO_TAG;
                            phase  = P_IDLE;
                        end
                    end
                    else
                        pos++;
                end
                P_FRAME_HDR:
                begin
                    if (pos == 0 && d == 8'h00)
                    begin
                        r.kind = KIND_WALK_END;
                        emit   = 1'b1;
                        phase  = P_IDLE;
                    end
                    else
                    begin
                        if (pos < 4)
                            ident = {ident[23:0], d};
                        else if (pos < 8)
                            acc = {acc[23:0], d};
                        if (pos >= 9)
                        begin
                            if (acc == 0)
                            begin
                                r.kind = KIND_WALK_END;
                                emit   = 1'b1;
                                phase  = P_IDLE;
                            end
                            else
                            begin
                                remaining = acc;
                                field     = FIELD_NONE;
                                for (i = 0; i < 6; i++)
                                    if (TEXT_IDS[i] == ident)
                                        field = field_t'(i);
                                text_open = 1'b0;
                                pos       = '0;
                                phase     = P_PAYLOAD;
                            end
                        end
                        else
                            pos++;
                    end
                end
                P_PAYLOAD:
                begin
                    remaining = remaining - 1;
                    last      = (remaining == 0);
                    if (pos == 0)
                    begin
                        // encoding byte: skip it, but a frame made of it alone
                        // still closes an empty field
                        pos = 4'd1;
                        if (field != FIELD_NONE)
                        begin
                            if (last)
                            begin
                                r.kind       = KIND_FIELD_END;
                                r.field_code = field;
                                emit         = 1'b1;
                            end
                            else
                                text_open = 1'b1;
                        end
                    end
                    else if (text_open)
                    begin
                        r.field_code = field;
                        emit         = 1'b1;
                        if (d == 8'h00)
                        begin
                            r.kind    = KIND_FIELD_END;
                            text_open = 1'b0;
                        end
                        else
                        begin
                            r.kind       = KIND_TEXT;
                            r.text_byte  = d;
                            r.ends_field = last;
                        end
                    end
                    if (last)
                        open_frame_header();
                end
                default: ;
            endcase
            if (emit)
                expected_q.push_back(r);
        endfunction

        function void flag(string why, out_item_t want, out_item_t got);
            failures++;
            if (failures <= 10)
                $display("%0t %s: expected kind %0d size %0h field %0d byte %0h end %0b",
                         $time, why, want.kind, want.tag_len, want.field_code,
                         want.text_byte, want.ends_field,
                         " / got kind %0d size %0h field %0d byte %0h end %0b",
                         got.kind, got.tag_len, got.field_code,
                         got.text_byte, got.ends_field);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0)
                flag("unexpected result", '0, got);
            else
            begin
                want = expected_q.pop_front();
                if (got.kind !== want.kind || got.tag_len !== want.tag_len ||
                    got.field_code !== want.field_code ||
                    got.text_byte !== want.text_byte ||
                    got.ends_field !== want.ends_field)
                    flag("result mismatch", want, got);
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n        = 1'b0;
    logic      byte_valid   = 1'b0;
    logic      byte_stall;
    in_item_t  byte_item    = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result_item;

    // Odds (percent) that an idle burst starts, per byte on the send side and
    // per cycle on the result side; re-picked for every file.
    int send_idle_pct   = 0;
    int result_idle_pct = 0;
    int stall_left      = 0;

    text_frame_scoreboard sb = new();

    id3v2_text_frame_parser_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the handshake locks up
    initial
    begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    // Result side: stall in bursts of random length, changing on falling edges
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left   = stall_left - 1;
            result_stall <= 1'b1;
        end
        else if (rst_n && result_idle_pct != 0 && $urandom_range(0, 99) < result_idle_pct)
        begin
            stall_left   = $urandom_range(0, 9);
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    // Check every result taken at a rising edge
    always @(posedge clk)
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result_item);

    // Offer one byte, maybe after an idle burst, and hold it until taken.
    task automatic send_byte(input logic [7:0] d, input logic restart_mark);
        in_item_t it;
        int       gap;
        it.data_byte  = d;
        it.first_byte = restart_mark;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 10);
            @(negedge clk);
            byte_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        byte_valid <= 1'b1;
        byte_item  <= it;
        do
            @(posedge clk);
        while (byte_stall);
        sb.note_byte(it);
    endtask

    // Send one frame header with the given size, then the first cut bytes of
    // its payload. Mostly text IDs; sometimes an unknown ID that gets skipped.
    task automatic send_frame(input logic [31:0] size, input int cut);
        logic [31:0] id;
        logic [7:0]  c;
        int          k;
        int          zero_at;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: id = TEXT_IDS[$urandom_range(0, 5)];
            7, 8: id = {8'($urandom_range(65, 90)), 8'($urandom_range(65, 90)),
                        8'($urandom_range(48, 90)), 8'($urandom_range(48, 90))};
            default: id = {8'($urandom_range(1, 255)), 24'($urandom)};
        endcase
        for (k = 0; k < 4; k++)
            send_byte(id[31 - 8 * k -: 8], 1'b0);
        for (k = 0; k < 4; k++)
            send_byte(size[31 - 8 * k -: 8], 1'b0);
        send_byte(8'($urandom), 1'b0);
        send_byte(8'($urandom), 1'b0);
        // a quarter of the payloads get a terminator if they are long enough; the
        // bytes after it must stay silent
        zero_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : -1;
        for (k = 0; k < cut; k++)
        begin
            if (k == 0)
                c = 8'($urandom_range(0, 3));
            else if (k == zero_at)
                c = 8'h00;
            else
                c = 8'($urandom_range(1, 255));
            send_byte(c, 1'b0);
        end
    endtask

    // One file: mostly a well-formed tag with random frames, sometimes noise,
    // a bad magic, or a frame cut short by the next restart.
    task automatic send_file();
        logic [7:0]  hdr [10];
        logic [31:0] size;
        int          mode;
        int          k;
        int          n;
        int          frames;
        mode = $urandom_range(0, 19);
        if (mode == 0)
        begin
            // noise, with a rare restart mark in the middle
            n = $urandom_range(5, 30);
            for (k = 0; k < n; k++)
                send_byte(8'($urandom), k == 0 || $urandom_range(0, 39) == 0);
            return;
        end
        hdr[0] = MAGIC_0;
        hdr[1] = MAGIC_1;
        hdr[2] = MAGIC_2;
        hdr[3] = 8'($urandom_range(2, 4));
        hdr[4] = 8'h00;
        hdr[5] = 8'($urandom);
        for (k = 6; k < 10; k++)
            hdr[k] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127));
        if (mode == 1)
            hdr[$urandom_range(0, 2)] ^= 8'(1 << $urandom_range(0, 7));
        for (k = 0; k < 10; k++)
            send_byte(hdr[k], k == 0);
        if (mode == 1)
        begin
            // no tag: the rest is ignored until the next restart
            n = $urandom_range(0, 4);
            for (k = 0; k < n; k++)
                send_byte(8'($urandom), 1'b0);
            return;
        end
        frames = $urandom_range(0, 5);
        for (k = 0; k < frames; k++)
        begin
            case ($urandom_range(0, 19))
                0: size = 32'd1;
                1: size = 32'($urandom_range(9, 60));
                default: size = 32'($urandom_range(2, 8));
            endcase
            send_frame(size, int'(size));
        end
        if (mode == 2)
        begin
            // any size, payload cut off by the next file
            send_frame(32'($urandom), $urandom_range(0, 20));
            return;
        end
        n = $urandom_range(0, 9);
        if (n < 6)
            send_byte(8'h00, 1'b0);
        else if (n < 8)
            send_frame(32'd0, 0);
        else
            return;
        n = $urandom_range(0, 3);
        for (k = 0; k < n; k++)
            send_byte(8'($urandom), 1'b0);
    endtask

    initial
    begin
        int k;
        bit drained;
        drained = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // the parser starts in the tag header phase, so no restart mark here
        for (k = 0; k < 23; k++)
            send_byte(OPENING[k], 1'b0);

        while (sb.live_bytes < ITEM_TARGET)
        begin
            if (sb.live_bytes >= ITEM_TARGET * 85 / 100)
            begin
                // final stretch runs at full rate on both sides
                send_idle_pct   = 0;
                result_idle_pct = 0;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0, 1: send_idle_pct = 0;
                    2: send_idle_pct = 10;
                    default: send_idle_pct = 40;
                endcase
                case ($urandom_range(0, 3))
                    0: result_idle_pct = 0;
                    1, 2: result_idle_pct = 5;
                    default: result_idle_pct = 20;
                endcase
            end
            if (!drained && sb.live_bytes >= ITEM_TARGET / 2)
            begin
                // hold the sender until every predicted result is out
                drained = 1'b1;
                @(negedge clk);
                byte_valid <= 1'b0;
                while (sb.pending() != 0)
                    @(posedge clk);
            end
            send_file();
        end

        @(negedge clk);
        byte_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        // give a stray late result time to show up
        repeat (16) @(posedge clk);
        if (sb.failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
